// ----- sv/apd_pkg.sv -----
// Package for the adaptive prediction image decoder.
// Holds sizes, register indexes and the queue item type; no dependencies.
`default_nettype none

package apd_pkg;

  localparam int MAX_LINE_WIDTH   = 1024;
  localparam int MAX_FRAME_HEIGHT = 4096;
  localparam int COL_W            = $clog2(MAX_LINE_WIDTH);
  localparam int ROW_W            = $clog2(MAX_FRAME_HEIGHT);

  localparam int RESIDUAL_W       = 10;
  localparam int PIXEL_W          = 8;
  localparam int LINE_WIDTH_W     = 11;
  localparam int FRAME_HEIGHT_W   = 13;
  localparam int CFG_DATA_W       = 13;
  localparam int CFG_INDEX_W      = 1;

  localparam int WCMP_W = (LINE_WIDTH_W > COL_W + 1) ? LINE_WIDTH_W : COL_W + 1;
  localparam int HCMP_W = (FRAME_HEIGHT_W > ROW_W + 1) ? FRAME_HEIGHT_W : ROW_W + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RST   = 11'd512;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd512;

  localparam logic [PIXEL_W-1:0] PIXEL_MID = 8'd128;
  localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'd255;

  typedef struct packed {
    logic signed [RESIDUAL_W-1:0] residual;
    logic [COL_W-1:0]             col;
    logic                         first_row;
    logic                         first_col;
    logic                         eol;
    logic                         eof;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

endpackage

`default_nettype wire

// ----- sv/apd_if.sv -----
// Stream interfaces for residuals in and pixels out.
// Depends on apd_pkg for field widths.
`default_nettype none

interface apd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [apd_pkg::RESIDUAL_W-1:0] residual;

  modport source (output valid, output residual, input ready);
  modport sink   (input valid, input residual, output ready);
endinterface

interface apd_out_if;
  logic                           valid;
  logic                           ready;
  logic [apd_pkg::PIXEL_W-1:0]    pixel;
  logic                           end_of_line;
  logic                           end_of_frame;

  modport source (output valid, output pixel, output end_of_line, output end_of_frame,
                  input ready);
  modport sink   (input valid, input pixel, input end_of_line, input end_of_frame,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/apd_front.sv -----
// Front end: configuration registers, input accept and raster position tracking.
// Depends on apd_pkg and apd_in_if.
`default_nettype none

module apd_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  apd_in_if.sink                                  in_ch,
  input  wire logic                               cfg_we,
  input  wire logic [apd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [apd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                               q_full,
  output apd_pkg::push_t                          push
);

  logic [apd_pkg::LINE_WIDTH_W-1:0]   line_width_r;
  logic [apd_pkg::FRAME_HEIGHT_W-1:0] frame_height_r;
  logic [apd_pkg::COL_W-1:0]          col_r, col_nxt;
  logic [apd_pkg::ROW_W-1:0]          row_r, row_nxt;
  logic [apd_pkg::WCMP_W-1:0]         w_raw, w_eff, col_inc;
  logic [apd_pkg::HCMP_W-1:0]         h_raw, h_eff, row_inc;
  logic                               accept, eol, eof;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= apd_pkg::LINE_WIDTH_RST;
      frame_height_r <= apd_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        apd_pkg::CFG_LINE_WIDTH:   line_width_r   <= cfg_wdata[apd_pkg::LINE_WIDTH_W-1:0];
        apd_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[apd_pkg::FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_raw = apd_pkg::WCMP_W'(line_width_r);
    if (w_raw < apd_pkg::WCMP_W'(2)) begin
      w_eff = apd_pkg::WCMP_W'(2);
    end else if (w_raw > apd_pkg::WCMP_W'(apd_pkg::MAX_LINE_WIDTH)) begin
      w_eff = apd_pkg::WCMP_W'(apd_pkg::MAX_LINE_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    h_raw = apd_pkg::HCMP_W'(frame_height_r);
    if (h_raw < apd_pkg::HCMP_W'(1)) begin
      h_eff = apd_pkg::HCMP_W'(1);
    end else if (h_raw > apd_pkg::HCMP_W'(apd_pkg::MAX_FRAME_HEIGHT)) begin
      h_eff = apd_pkg::HCMP_W'(apd_pkg::MAX_FRAME_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
    col_inc = apd_pkg::WCMP_W'(col_r) + apd_pkg::WCMP_W'(1);
    row_inc = apd_pkg::HCMP_W'(row_r) + apd_pkg::HCMP_W'(1);
    eol     = (col_inc >= w_eff);
    eof     = eol && (row_inc >= h_eff);
    if (eol) begin
      col_nxt = '0;
      row_nxt = eof ? '0 : row_inc[apd_pkg::ROW_W-1:0];
    end else begin
      col_nxt = col_inc[apd_pkg::COL_W-1:0];
      row_nxt = row_r;
    end
  end

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    push.valid               = accept;
    push.item.residual       = in_ch.residual;
    push.item.col            = col_r;
    push.item.first_row      = (row_r == '0);
    push.item.first_col      = (col_r == '0);
    push.item.eol            = eol;
    push.item.eof            = eof;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/apd_queue.sv -----
// Short queue of classified items between front and back end.
// Depends on apd_pkg.
`default_nettype none

module apd_queue (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire apd_pkg::push_t push,
  output logic          full,
  input  wire logic     pop,
  output logic          head_valid,
  output apd_pkg::item_t head
);

  apd_pkg::item_t                entry_r [apd_pkg::QUEUE_DEPTH];
  logic [apd_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [apd_pkg::QCNT_W-1:0]    count_r, count_nxt;
  logic                          do_pop;

  assign full       = (count_r == apd_pkg::QCNT_W'(apd_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entry_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (push.valid && !do_pop) begin
      count_nxt = count_r + apd_pkg::QCNT_W'(1);
    end else if (!push.valid && do_pop) begin
      count_nxt = count_r - apd_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry_r[wr_ptr_r] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push.valid) begin
        wr_ptr_r <= (wr_ptr_r == apd_pkg::QPTR_W'(apd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                         : wr_ptr_r + apd_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == apd_pkg::QPTR_W'(apd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                         : rd_ptr_r + apd_pkg::QPTR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/apd_back.sv -----
// Back end: line buffer read, gradient predictor, reconstruction and output register.
// Depends on apd_pkg and apd_out_if.
`default_nettype none

module apd_back (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      head_valid,
  input  wire apd_pkg::item_t head,
  output logic           pop,
  apd_out_if.source      out_ch
);

  logic [apd_pkg::PIXEL_W-1:0] line_mem [apd_pkg::MAX_LINE_WIDTH];

  logic                         s1_valid_r;
  apd_pkg::item_t               s1_item_r;
  logic [apd_pkg::PIXEL_W-1:0]  above_r;
  logic [apd_pkg::PIXEL_W-1:0]  left_r, upleft_r;
  logic                         out_valid_r;
  logic [apd_pkg::PIXEL_W-1:0]  out_pixel_r;
  logic                         out_eol_r, out_eof_r;

  logic                         adv;
  logic [apd_pkg::PIXEL_W-1:0]  diff_ba, diff_bc, pred, pix;
  logic signed [apd_pkg::RESIDUAL_W:0] sum;

  assign adv = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign pop = head_valid && (!s1_valid_r || adv);

  always_comb begin
    diff_ba = (upleft_r >= left_r)  ? upleft_r - left_r  : left_r - upleft_r;
    diff_bc = (upleft_r >= above_r) ? upleft_r - above_r : above_r - upleft_r;
    if (s1_item_r.first_row && s1_item_r.first_col) begin
      pred = apd_pkg::PIXEL_MID;
    end else if (s1_item_r.first_row) begin
      pred = left_r;
    end else if (s1_item_r.first_col) begin
      pred = above_r;
    end else begin
      pred = (diff_bc <= diff_ba) ? left_r : above_r;
    end
    sum = $signed({3'b000, pred})
        + $signed({s1_item_r.residual[apd_pkg::RESIDUAL_W-1], s1_item_r.residual});
    if (sum[apd_pkg::RESIDUAL_W]) begin
      pix = '0;
    end else if (sum[apd_pkg::RESIDUAL_W-1:apd_pkg::PIXEL_W] != '0) begin
      pix = apd_pkg::PIXEL_MAX;
    end else begin
      pix = sum[apd_pkg::PIXEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      line_mem[s1_item_r.col] <= pix;
    end
    if (pop) begin
      above_r   <= line_mem[head.col];
      s1_item_r <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel_r <= pix;
      out_eol_r   <= s1_item_r.eol;
      out_eof_r   <= s1_item_r.eof;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      left_r      <= '0;
      upleft_r    <= '0;
    end else begin
      if (pop) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        left_r      <= pix;
        upleft_r    <= above_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel        = out_pixel_r;
  assign out_ch.end_of_line  = out_eol_r;
  assign out_ch.end_of_frame = out_eof_r;

endmodule

`default_nettype wire

// ----- sv/adaptive_pred_image_decoder_unit.sv -----
// Top level of the adaptive prediction image decoder: front end, queue, back end.
// Depends on apd_pkg, apd_if, apd_front, apd_queue and apd_back.
//
//   channel  direction  payload                              handshake
//   in_ch    sink       residual (10b signed)                valid/ready
//   out_ch   source     pixel (8b), end_of_line, end_of_frame valid/ready
//   cfg      write      cfg_index (1b), cfg_wdata (13b)      cfg_we
//
// One residual per cycle sustained while out_ch.ready stays high; out_ch.valid rises after
// its transaction passes the queue entry, line buffer read stage and output register.
// The line buffer is read one stage ahead of the predictor.
// Synchronous active-low reset clears positions and pipeline state; the line
// buffer is not cleared. A stalled output holds the back end while the queue
// keeps taking transactions until full.
`default_nettype none

module adaptive_pred_image_decoder_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  apd_in_if.sink                               in_ch,
  apd_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [apd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [apd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  apd_pkg::push_t push;
  apd_pkg::item_t head;
  logic           q_full, head_valid, pop;

  apd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push)
  );

  apd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  apd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
